// ----- design/ial_pkg.sv -----
// Package for the indexed array list: command and status codes,
// sequencer states and the result word type. No dependencies.
`default_nettype none

package ial_pkg;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_INSERT_AT  = 3'd1;
    localparam logic [2:0] CMD_REMOVE_VAL = 3'd2;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd3;
    localparam logic [2:0] CMD_CLEAR      = 3'd4;
    localparam logic [2:0] CMD_GET        = 3'd5;
    localparam logic [2:0] CMD_FIND       = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_GET_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       empty_res;
        logic [6:0] count;
        logic [5:0] found_index;
        logic [31:0] data;
        logic [1:0] status;
    } t_result;

endpackage

`default_nettype wire

// ----- design/ial_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ial_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/ial_ctrl.sv -----
// Sequencer and datapath of the list: walks the entry RAM with one
// pointer and one compare. Depends on ial_pkg.
`default_nettype none

module ial_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [2:0]                  i_cmd,
    input  wire logic [31:0]                 i_value,
    input  wire logic [5:0]                  i_index,
    input  wire logic                        i_out_free,
    output logic                             o_ready,
    output logic                             o_done,
    output ial_pkg::t_result                 o_result,
    output logic                             o_we,
    output logic [$clog2(CAPACITY)-1:0]      o_waddr,
    output logic [DATA_WIDTH-1:0]            o_wdata,
    output logic [$clog2(CAPACITY)-1:0]      o_raddr,
    input  wire logic [DATA_WIDTH-1:0]       i_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 6) ? CW : 6;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    ial_pkg::t_state r_state, n_state;

    logic [2:0]            r_cmd;
    logic [DATA_WIDTH-1:0] r_val;
    logic [5:0]            r_idx;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_ptr;
    logic [1:0]            r_status;
    logic [DATA_WIDTH-1:0] r_data;
    logic [5:0]            r_fidx;

    logic [CW-1:0] w_ptr_inc;
    logic [CW-1:0] w_ptr_dec;
    logic [CW-1:0] w_idx_c;
    logic          w_idx_bad;
    logic          w_full;
    logic          w_hit;
    logic          w_last;

    assign w_ptr_inc = r_ptr + CW'(1);
    assign w_ptr_dec = r_ptr - CW'(1);
    assign w_idx_c   = CW'(r_idx);
    assign w_idx_bad = XW'(r_idx) >= XW'(r_count);
    assign w_full    = r_count >= CAP_C;
    assign w_hit     = i_rdata == r_val;
    assign w_last    = w_ptr_inc >= r_count;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ial_pkg::S_IDLE: begin
                if (i_start) n_state = ial_pkg::S_EXEC;
            end
            ial_pkg::S_EXEC: begin
                case (r_cmd)
                    ial_pkg::CMD_INSERT_AT: begin
                        if (w_idx_bad || w_full) n_state = ial_pkg::S_DONE;
                        else                     n_state = ial_pkg::S_INS_RD;
                    end
                    ial_pkg::CMD_REMOVE_VAL, ial_pkg::CMD_FIND: begin
                        if (r_count == '0) n_state = ial_pkg::S_DONE;
                        else               n_state = ial_pkg::S_SRCH_RD;
                    end
                    ial_pkg::CMD_REMOVE_AT: begin
                        if (w_idx_bad) n_state = ial_pkg::S_DONE;
                        else           n_state = ial_pkg::S_DEL_RD;
                    end
                    ial_pkg::CMD_GET: begin
                        if (w_idx_bad) n_state = ial_pkg::S_DONE;
                        else           n_state = ial_pkg::S_GET_WAIT;
                    end
                    default: n_state = ial_pkg::S_DONE;
                endcase
            end
            ial_pkg::S_INS_RD: begin
                if (r_ptr == w_idx_c) n_state = ial_pkg::S_DONE;
                else                  n_state = ial_pkg::S_INS_WR;
            end
            ial_pkg::S_INS_WR:   n_state = ial_pkg::S_INS_RD;
            ial_pkg::S_SRCH_RD:  n_state = ial_pkg::S_SRCH_CMP;
            ial_pkg::S_SRCH_CMP: begin
                if (w_hit) begin
                    if (r_cmd == ial_pkg::CMD_FIND) n_state = ial_pkg::S_DONE;
                    else                            n_state = ial_pkg::S_DEL_RD;
                end else if (w_last) begin
                    n_state = ial_pkg::S_DONE;
                end else begin
                    n_state = ial_pkg::S_SRCH_RD;
                end
            end
            ial_pkg::S_DEL_RD: begin
                if (w_last) n_state = ial_pkg::S_DONE;
                else        n_state = ial_pkg::S_DEL_WR;
            end
            ial_pkg::S_DEL_WR:   n_state = ial_pkg::S_DEL_RD;
            ial_pkg::S_GET_WAIT: n_state = ial_pkg::S_DONE;
            ial_pkg::S_DONE: begin
                if (i_out_free) n_state = ial_pkg::S_IDLE;
            end
            default: n_state = ial_pkg::S_IDLE;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        o_ready = r_state == ial_pkg::S_IDLE;
        o_done  = (r_state == ial_pkg::S_DONE) && i_out_free;
        o_we    = 1'b0;
        o_waddr = r_ptr[AW-1:0];
        o_wdata = i_rdata;
        o_raddr = r_ptr[AW-1:0];
        case (r_state)
            ial_pkg::S_EXEC: begin
                o_raddr = w_idx_c[AW-1:0];
                if (r_cmd == ial_pkg::CMD_APPEND && !w_full) begin
                    o_we    = 1'b1;
                    o_waddr = r_count[AW-1:0];
                    o_wdata = r_val;
                end
            end
            ial_pkg::S_INS_RD: begin
                o_raddr = w_ptr_dec[AW-1:0];
                if (r_ptr == w_idx_c) begin
                    o_we    = 1'b1;
                    o_wdata = r_val;
                end
            end
            ial_pkg::S_INS_WR: o_we = 1'b1;
            ial_pkg::S_DEL_RD: o_raddr = w_ptr_inc[AW-1:0];
            ial_pkg::S_DEL_WR: o_we = 1'b1;
            default: ;
        endcase
        o_result.status      = r_status;
        o_result.data        = 32'(r_data);
        o_result.found_index = r_fidx;
        o_result.count       = 7'(r_count);
        o_result.empty_res   = r_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ial_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ial_pkg::S_EXEC: begin
                    case (r_cmd)
                        ial_pkg::CMD_APPEND: begin
                            if (!w_full) r_count <= r_count + CW'(1);
                        end
                        ial_pkg::CMD_CLEAR: r_count <= '0;
                        default: ;
                    endcase
                end
                ial_pkg::S_INS_RD: begin
                    if (r_ptr == w_idx_c) r_count <= r_count + CW'(1);
                end
                ial_pkg::S_DEL_RD: begin
                    if (w_last) r_count <= r_count - CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ial_pkg::S_IDLE: begin
                if (i_start) begin
                    r_cmd    <= i_cmd;
                    r_val    <= DATA_WIDTH'(i_value);
                    r_idx    <= i_index;
                    r_status <= ial_pkg::ST_OK;
                    r_data   <= '0;
                    r_fidx   <= '0;
                end
            end
            ial_pkg::S_EXEC: begin
                case (r_cmd)
                    ial_pkg::CMD_APPEND: begin
                        if (w_full) r_status <= ial_pkg::ST_FULL;
                    end
                    ial_pkg::CMD_INSERT_AT: begin
                        r_ptr <= r_count;
                        if (w_idx_bad)   r_status <= ial_pkg::ST_RANGE;
                        else if (w_full) r_status <= ial_pkg::ST_FULL;
                    end
                    ial_pkg::CMD_REMOVE_VAL, ial_pkg::CMD_FIND: begin
                        r_ptr <= '0;
                        if (r_count == '0) r_status <= ial_pkg::ST_NOTFOUND;
                    end
                    ial_pkg::CMD_REMOVE_AT, ial_pkg::CMD_GET: begin
                        r_ptr <= w_idx_c;
                        if (w_idx_bad) r_status <= ial_pkg::ST_RANGE;
                    end
                    default: ;
                endcase
            end
            ial_pkg::S_INS_WR: r_ptr <= w_ptr_dec;
            ial_pkg::S_SRCH_CMP: begin
                if (w_hit) begin
                    if (r_cmd == ial_pkg::CMD_FIND) r_fidx <= 6'(r_ptr);
                end else if (w_last) begin
                    r_status <= ial_pkg::ST_NOTFOUND;
                end else begin
                    r_ptr <= w_ptr_inc;
                end
            end
            ial_pkg::S_DEL_WR:   r_ptr  <= w_ptr_inc;
            ial_pkg::S_GET_WAIT: r_data <= i_rdata;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/indexed_array_list_top.sv -----
// Top level of the indexed array list: stream ports, output word register,
// sequencer and entry RAM. Depends on ial_pkg, ial_ram and ial_ctrl.
//
//   port group  dir  word layout
//   s_axis      in   tuser[2:0] cmd; tdata[31:0] value, [37:32] index
//   m_axis      out  tdata[1:0] status, [33:2] data, [39:34] found_index,
//                    [46:40] count, [47] empty_res
//
// One word at a time. Append, clear, bad index or unused code finish from the
// execute state; get adds a wait for the RAM read. Find and remove value scan
// one entry per read and compare; insert and the shift of a removal move one
// entry per read then write of the entry RAM.
// Reset clears the count, the sequencer state and the output valid flag;
// the RAM is not cleared. A finished word waits in the output register; the
// next word is taken meanwhile and its result is held until the register frees.
`default_nettype none

module indexed_array_list_top #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value, index, pad
    input  wire logic [2:0]  s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // status, data, found_index, count, empty_res
);

    localparam int AW = $clog2(CAPACITY);

    logic                  w_ready;
    logic                  w_start;
    logic                  w_done;
    logic                  w_out_free;
    ial_pkg::t_result      w_result;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    logic             r_out_valid;
    ial_pkg::t_result r_out;

    assign s_axis_tready = w_ready;
    assign w_start       = s_axis_tvalid && w_ready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    ial_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_cmd      (s_axis_tuser),
        .i_value    (s_axis_tdata[31:0]),
        .i_index    (s_axis_tdata[37:32]),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_done     (w_done),
        .o_result   (w_result),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata)
    );

    ial_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.empty_res, r_out.count, r_out.found_index,
                            r_out.data, r_out.status};

endmodule

`default_nettype wire

// ----- tb/indexed_array_list_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for indexed_array_list_top: stream driver and receiver with random
// gaps, and a list scoreboard that predicts every result word. Uses ial_pkg.

module indexed_array_list_top_tb;

    localparam int CAPACITY     = 64;
    localparam int DATA_WIDTH   = 32;
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_WORDS = 1075;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 4 * CAPACITY + 20;
    localparam int PH_FILL      = 0;
    localparam int PH_DRAIN     = 1;
    localparam int PH_MIXED     = 2;

    class list_scoreboard;
        logic [31:0]      entries [CAPACITY];
        int               n_entries;
        ial_pkg::t_result pending_results[$];
        int               mismatches;
        int               words_checked;
        int               status_hits[4];
        int               full_reached;
        int               empty_reached;

        function new();
            n_entries     = 0;
            mismatches    = 0;
            words_checked = 0;
            full_reached  = 0;
            empty_reached = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function int locate(logic [31:0] value);
            for (int i = 0; i < n_entries; i++) begin
                if (entries[i] == value) return i;
            end
            return -1;
        endfunction

        function void drop_at(int pos);
            for (int i = pos; i + 1 < n_entries; i++) entries[i] = entries[i + 1];
            n_entries--;
        endfunction

        // predict one result word and update the list copy
        function void apply_command(logic [2:0] cmd, logic [31:0] value, logic [5:0] index);
            ial_pkg::t_result r;
            int               pos;
            int               prev;
            prev     = n_entries;
            r        = '0;
            r.status = ial_pkg::ST_OK;
            case (cmd)
                ial_pkg::CMD_APPEND: begin
                    if (n_entries >= CAPACITY) begin
                        r.status = ial_pkg::ST_FULL;
                    end else begin
                        entries[n_entries] = value;
                        n_entries++;
                    end
                end
                ial_pkg::CMD_INSERT_AT: begin
                    if (int'(index) >= n_entries) begin
                        r.status = ial_pkg::ST_RANGE;
                    end else if (n_entries >= CAPACITY) begin
                        r.status = ial_pkg::ST_FULL;
                    end else begin
                        for (int i = n_entries; i > int'(index); i--)
                            entries[i] = entries[i - 1];
                        entries[index] = value;
                        n_entries++;
                    end
                end
                ial_pkg::CMD_REMOVE_VAL: begin
                    pos = locate(value);
                    if (pos >= 0) drop_at(pos);
                    else r.status = ial_pkg::ST_NOTFOUND;
                end
                ial_pkg::CMD_REMOVE_AT: begin
                    if (int'(index) >= n_entries) r.status = ial_pkg::ST_RANGE;
                    else drop_at(int'(index));
                end
                ial_pkg::CMD_CLEAR: begin
                    n_entries = 0;
                end
                ial_pkg::CMD_GET: begin
                    if (int'(index) >= n_entries) r.status = ial_pkg::ST_RANGE;
                    else r.data = entries[index];
                end
                ial_pkg::CMD_FIND: begin
                    pos = locate(value);
                    if (pos >= 0) r.found_index = 6'(pos);
                    else r.status = ial_pkg::ST_NOTFOUND;
                end
                default: begin
                end
            endcase
            r.count     = 7'(n_entries);
            r.empty_res = (n_entries == 0);
            if (n_entries == CAPACITY && prev < CAPACITY) full_reached++;
            if (n_entries == 0 && prev > 0) empty_reached++;
            status_hits[r.status]++;
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [47:0] word);
            ial_pkg::t_result got;
            ial_pkg::t_result want;
            got = ial_pkg::t_result'(word);
            words_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", word);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.found_index !== want.found_index || got.count !== want.count ||
                got.empty_res !== want.empty_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected status %0d data %h index %0d count %0d empty %0b",
                             words_checked, want.status, want.data, want.found_index,
                             want.count, want.empty_res);
                    $display("result %0d:      got status %0d data %h index %0d count %0d empty %0b",
                             words_checked, got.status, got.data, got.found_index,
                             got.count, got.empty_res);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // value, index, pad
    logic [2:0]  s_axis_tuser = '0;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // status, data, found_index, count, empty_res

    list_scoreboard sb;
    int  words_sent = 0;
    int  idle_cycles = 0;
    bit  send_busy = 1'b0;

    indexed_array_list_top #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap(bit busy);
        int r;
        if (!busy) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && sb.n_entries > 0) return sb.entries[$urandom_range(0, sb.n_entries - 1)];
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [5:0] pick_index();
        int top;
        top = (sb.n_entries > 63) ? 63 : sb.n_entries;
        if ($urandom_range(0, 99) < 70) return 6'($urandom_range(0, top));
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [2:0] pick_cmd(int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL: begin
                if (r < 75) return ial_pkg::CMD_APPEND;
                if (r < 95) return ial_pkg::CMD_INSERT_AT;
                if (r < 98) return ial_pkg::CMD_GET;
                return ial_pkg::CMD_FIND;
            end
            PH_DRAIN: begin
                if (r < 35) return ial_pkg::CMD_REMOVE_AT;
                if (r < 70) return ial_pkg::CMD_REMOVE_VAL;
                if (r < 80) return ial_pkg::CMD_GET;
                if (r < 90) return ial_pkg::CMD_FIND;
                return ial_pkg::CMD_APPEND;
            end
            default: begin
                if (r < 2) return ial_pkg::CMD_CLEAR;
                if (r < 4) return CMD_UNUSED;
                case ($urandom_range(0, 5))
                    0: return ial_pkg::CMD_APPEND;
                    1: return ial_pkg::CMD_INSERT_AT;
                    2: return ial_pkg::CMD_REMOVE_VAL;
                    3: return ial_pkg::CMD_REMOVE_AT;
                    4: return ial_pkg::CMD_GET;
                    default: return ial_pkg::CMD_FIND;
                endcase
            end
        endcase
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] value,
                            input logic [5:0] index);
        int gap;
        gap = pick_gap(send_busy);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, index, value};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.apply_command(cmd, value, index);
        words_sent++;
    endtask

    task automatic run_phase(input int phase, input int len);
        logic [2:0] cmd;
        for (int i = 0; i < len; i++) begin
            cmd = pick_cmd(phase);
            send_cmd(cmd, pick_value(), pick_index());
        end
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        bit held;
        bit busy;
        held = 1'b0;
        busy = 1'b1;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (sb.words_checked % 80 == 0) busy = ($urandom_range(0, 3) != 0);
            gap = pick_gap(busy);
            if (!held && sb.words_checked >= HOLD_AT) begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int failures;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        send_cmd(ial_pkg::CMD_GET, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_INSERT_AT, 32'h1, 6'd0);
        send_cmd(ial_pkg::CMD_REMOVE_AT, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_REMOVE_VAL, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_FIND, 32'h0, 6'd0);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send_cmd(ial_pkg::CMD_CLEAR, 32'h0, 6'd0);
        // small list, duplicates, boundary indexes
        send_cmd(ial_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd63);
        send_cmd(ial_pkg::CMD_APPEND, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_INSERT_AT, 32'h8000_0001, 6'd0);
        send_cmd(ial_pkg::CMD_INSERT_AT, 32'h1234_5678, 6'd2);
        send_cmd(ial_pkg::CMD_APPEND, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_GET, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_GET, 32'h0, 6'd4);
        send_cmd(ial_pkg::CMD_GET, 32'h0, 6'd5);
        send_cmd(ial_pkg::CMD_GET, 32'h0, 6'd63);
        send_cmd(ial_pkg::CMD_FIND, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_REMOVE_VAL, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_FIND, 32'h1234_5678, 6'd0);
        send_cmd(ial_pkg::CMD_REMOVE_AT, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_REMOVE_AT, 32'h0, 6'd63);
        send_cmd(ial_pkg::CMD_INSERT_AT, 32'h0, 6'd63);
        send_cmd(ial_pkg::CMD_CLEAR, 32'h0, 6'd0);
        send_cmd(ial_pkg::CMD_APPEND, 32'h5A5A_5A5A, 6'd0);
        send_cmd(ial_pkg::CMD_FIND, 32'hFFFF_FFFF, 6'd0);

        send_busy = 1'b1;
        run_phase(PH_FILL, 110);
        run_phase(PH_DRAIN, 140);
        while (words_sent < 25 + RANDOM_WORDS) begin
            send_busy = ($urandom_range(0, 3) != 0);
            run_phase($urandom_range(PH_FILL, PH_MIXED), $urandom_range(20, 120));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        failures = sb.mismatches + sb.pending_results.size();
        $display("%0d commands sent, %0d results checked, %0d mismatches",
                 words_sent, sb.words_checked, failures);
        $display("status ok/range/notfound/full: %0d/%0d/%0d/%0d; list full %0d times, emptied %0d times",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
                 sb.full_reached, sb.empty_reached);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
